// ===== src/etok_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character classifiers for the expression tokenizer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package etok_pkg;

   // Field widths of one result item.
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned SYM_W   = 8;
   localparam int unsigned NAME_W  = 32;
   localparam int unsigned MANT_W  = 30;
   localparam int unsigned FRAC_W  = 4;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned RUN_W   = 4;

   // Token kinds as they appear on the result channel.
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OPER    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BRACKET = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NAME    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END     = 3'd4;

   // Character codes.
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_DIGIT0  = 8'h30;
   localparam logic [7:0] CH_DIGIT9  = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   // One character causes at most three tokens: a flushed run, its own token, the end token.
   localparam int unsigned NUM_SLOTS = 3;
   localparam int unsigned SLOT_W    = 2;
   localparam logic [SLOT_W-1:0] SLOT_RUN = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_OWN = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_END = 2'd2;

   // Depth of the queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SYM_W-1:0]   symbol;
      logic [NAME_W-1:0]  name_chars;
      logic [MANT_W-1:0]  mantissa;
      logic [FRAC_W-1:0]  frac_digits;
      logic [INDEX_W-1:0] token_index;
      logic               run_truncated;
      logic               table_full;
   } token_type;

   // All tokens caused by one character, in emission order.
   typedef struct packed {
      logic [NUM_SLOTS-1:0]      vld;
      token_type [NUM_SLOTS-1:0] tok;
   } entry_type;

   function automatic logic is_op_char(input logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
             c == CH_CARET || c == CH_PERCENT || c == CH_TILDE || c == CH_COLON ||
             c == CH_BANG || c == CH_PIPE;
   endfunction

   function automatic logic is_bracket_char(input logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK;
   endfunction

   function automatic logic is_letter_char(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   endfunction

   function automatic logic is_digit_char(input logic [7:0] c);
      return c >= CH_DIGIT0 && c <= CH_DIGIT9;
   endfunction

endpackage

// ===== src/expression_tokenizer_core.sv =====
`timescale 1ns / 1ps
// Expression tokenizer top level: front part, token group queue and back part.
// The first result of a character passes through the queue and then the output register.
// Throughput: one character per cycle while the two-entry queue has room; the back part sends
// one result per cycle while the receiver is ready, so a character causing up to three results
// occupies the output for each of them in turn and the input stalls once the queue is full.
// Reset is synchronous and clears the pending run, token count, queue and output valid.
module expression_tokenizer_core #(
   parameter int unsigned MAX_TOKENS       = 32,
   parameter int unsigned MAX_NUMBER_CHARS = 9,
   parameter int unsigned MAX_NAME_CHARS   = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_last_char,
   input  logic                         req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [etok_pkg::KIND_W-1:0]  rsp_token_kind,
   output logic [etok_pkg::SYM_W-1:0]   rsp_symbol,
   output logic [etok_pkg::NAME_W-1:0]  rsp_name_chars,
   output logic [etok_pkg::MANT_W-1:0]  rsp_mantissa,
   output logic [etok_pkg::FRAC_W-1:0]  rsp_frac_digits,
   output logic [etok_pkg::INDEX_W-1:0] rsp_token_index,
   output logic                         rsp_run_truncated,
   output logic                         rsp_table_full,
   output logic                         rsp_last_of_run
);

   logic                q_full;
   logic                push;
   logic                pop;
   logic                head_valid;
   etok_pkg::entry_type push_entry;
   etok_pkg::entry_type head_entry;

   // Character classification and run tracking.
   etok_front #(
      .MAX_TOKENS       (MAX_TOKENS),
      .MAX_NUMBER_CHARS (MAX_NUMBER_CHARS),
      .MAX_NAME_CHARS   (MAX_NAME_CHARS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Decoupling queue.
   etok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Result sequencing and output register.
   etok_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_symbol        (rsp_symbol),
      .rsp_name_chars    (rsp_name_chars),
      .rsp_mantissa      (rsp_mantissa),
      .rsp_frac_digits   (rsp_frac_digits),
      .rsp_token_index   (rsp_token_index),
      .rsp_run_truncated (rsp_run_truncated),
      .rsp_table_full    (rsp_table_full),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == etok_pkg::KIND_END |-> rsp_last_of_run)
      else $error("end token not marked as last result of its item");
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full && rsp_token_kind != etok_pkg::KIND_END
      |-> rsp_token_index == etok_pkg::INDEX_W'(MAX_TOKENS))
      else $error("token flagged table full with an index below the table size");
   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == etok_pkg::KIND_NUMBER
      |-> rsp_frac_digits < etok_pkg::FRAC_W'(MAX_NUMBER_CHARS))
      else $error("number token has more fraction digits than characters kept");

endmodule

// ===== src/etok_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts characters, tracks the pending run and builds the tokens of each item.
// Depends on etok_pkg; feeds etok_queue.
module etok_front #(
   parameter int unsigned MAX_TOKENS       = 32,
   parameter int unsigned MAX_NUMBER_CHARS = 9,
   parameter int unsigned MAX_NAME_CHARS   = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_char_code,
   input  logic                req_last_char,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                q_full,
   output logic                push,
   output etok_pkg::entry_type push_entry
);

   localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKENS);

   typedef enum logic [1:0] {PEND_NONE, PEND_NUMBER, PEND_NAME} pend_type;

   pend_type                       pend_ff, pend_in;
   logic [etok_pkg::MANT_W-1:0]    value_ff, value_in;
   logic [etok_pkg::FRAC_W-1:0]    frac_ff, frac_in;
   logic                           dot_ff, dot_in;
   logic                           stop_ff, stop_in;
   logic [etok_pkg::RUN_W-1:0]     len_ff, len_in;
   logic [etok_pkg::NAME_W-1:0]    name_ff, name_in;
   logic                           over_ff, over_in;
   logic [CNT_W-1:0]               count_ff, count_in;

   logic                           accept;
   logic                           c_num, c_letter, c_op, c_bracket;
   logic                           change;
   pend_type                       n_pend;
   logic [etok_pkg::MANT_W-1:0]    b_value, n_value;
   logic [etok_pkg::FRAC_W-1:0]    b_frac, n_frac;
   logic                           b_dot, n_dot, b_stop, n_stop, b_over, n_over;
   logic [etok_pkg::RUN_W-1:0]     b_len, n_len;
   logic [etok_pkg::NAME_W-1:0]    b_name, n_name;
   logic [CNT_W-1:0]               cnt1, cnt2;
   etok_pkg::token_type            old_tok, new_tok, own_tok, end_tok;
   etok_pkg::entry_type            entry;

   function automatic logic [CNT_W-1:0] advance(input logic [CNT_W-1:0] cnt);
      return (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
   endfunction

   // Builds a run token from a run state.
   function automatic etok_pkg::token_type run_token(
      input pend_type                    kind,
      input logic [etok_pkg::MANT_W-1:0] value,
      input logic [etok_pkg::FRAC_W-1:0] frac,
      input logic [etok_pkg::NAME_W-1:0] name,
      input logic                        over
   );
      etok_pkg::token_type t;
      t = '0;
      t.run_truncated = over;
      if (kind == PEND_NAME) begin
         t.kind       = etok_pkg::KIND_NAME;
         t.name_chars = name;
      end else begin
         t.kind        = etok_pkg::KIND_NUMBER;
         t.mantissa    = value;
         t.frac_digits = frac;
      end
      return t;
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   // Classify the character and decide whether the pending run ends here.
   always_comb begin
      c_letter  = etok_pkg::is_letter_char(req_char_code);
      c_num     = etok_pkg::is_digit_char(req_char_code) || req_char_code == etok_pkg::CH_DOT;
      c_op      = etok_pkg::is_op_char(req_char_code);
      c_bracket = etok_pkg::is_bracket_char(req_char_code);
      if (c_num) begin
         change = pend_ff != PEND_NUMBER;
      end else if (c_letter) begin
         change = pend_ff != PEND_NAME;
      end else begin
         change = 1'b1;
      end
   end

   // Run state after this character: start from a cleared run when the class changes.
   always_comb begin
      b_value = change ? '0 : value_ff;
      b_frac  = change ? '0 : frac_ff;
      b_dot   = change ? 1'b0 : dot_ff;
      b_stop  = change ? 1'b0 : stop_ff;
      b_len   = change ? '0 : len_ff;
      b_name  = change ? '0 : name_ff;
      b_over  = change ? 1'b0 : over_ff;
      n_value = b_value;
      n_frac  = b_frac;
      n_dot   = b_dot;
      n_stop  = b_stop;
      n_len   = b_len;
      n_name  = b_name;
      n_over  = b_over;
      n_pend  = PEND_NONE;
      if (c_num) begin
         n_pend = PEND_NUMBER;
         if (b_len >= etok_pkg::RUN_W'(MAX_NUMBER_CHARS)) begin
            n_over = 1'b1;
         end else begin
            n_len = b_len + etok_pkg::RUN_W'(1);
            if (req_char_code == etok_pkg::CH_DOT) begin
               n_stop = b_stop || b_dot;
               n_dot  = 1'b1;
            end else if (!b_stop) begin
               // Multiply by ten as two shifts and add the digit.
               n_value = etok_pkg::MANT_W'({b_value, 3'b000}) +
                         etok_pkg::MANT_W'({b_value, 1'b0}) +
                         etok_pkg::MANT_W'(req_char_code[3:0]);
               if (b_dot) begin
                  n_frac = b_frac + etok_pkg::FRAC_W'(1);
               end
            end
         end
      end else if (c_letter) begin
         n_pend = PEND_NAME;
         if (b_len >= etok_pkg::RUN_W'(MAX_NAME_CHARS)) begin
            n_over = 1'b1;
         end else begin
            n_name[{b_len[1:0], 3'b000} +: 8] = req_char_code;
            n_len = b_len + etok_pkg::RUN_W'(1);
         end
      end
   end

   // Assemble the tokens of this character and give each its index.
   always_comb begin
      old_tok = run_token(pend_ff, value_ff, frac_ff, name_ff, over_ff);
      new_tok = run_token(n_pend, n_value, n_frac, n_name, n_over);

      own_tok        = '0;
      own_tok.symbol = req_char_code;
      own_tok.kind   = c_op ? etok_pkg::KIND_OPER : etok_pkg::KIND_BRACKET;

      entry = '0;
      entry.vld[etok_pkg::SLOT_RUN] = change && pend_ff != PEND_NONE;
      entry.tok[etok_pkg::SLOT_RUN] = old_tok;
      entry.tok[etok_pkg::SLOT_RUN].token_index = etok_pkg::INDEX_W'(count_ff);
      entry.tok[etok_pkg::SLOT_RUN].table_full  = count_ff == CNT_MAX;
      cnt1 = entry.vld[etok_pkg::SLOT_RUN] ? advance(count_ff) : count_ff;

      if (c_op || c_bracket) begin
         entry.vld[etok_pkg::SLOT_OWN] = 1'b1;
         entry.tok[etok_pkg::SLOT_OWN] = own_tok;
      end else begin
         entry.vld[etok_pkg::SLOT_OWN] = req_last_char && (c_num || c_letter);
         entry.tok[etok_pkg::SLOT_OWN] = new_tok;
      end
      entry.tok[etok_pkg::SLOT_OWN].token_index = etok_pkg::INDEX_W'(cnt1);
      entry.tok[etok_pkg::SLOT_OWN].table_full  = cnt1 == CNT_MAX;
      cnt2 = entry.vld[etok_pkg::SLOT_OWN] ? advance(cnt1) : cnt1;

      end_tok             = '0;
      end_tok.kind        = etok_pkg::KIND_END;
      end_tok.token_index = etok_pkg::INDEX_W'(cnt2);
      end_tok.table_full  = cnt2 == CNT_MAX;
      entry.vld[etok_pkg::SLOT_END] = req_last_char;
      entry.tok[etok_pkg::SLOT_END] = end_tok;
   end

   assign push       = accept && (entry.vld != '0);
   assign push_entry = entry;

   // Next state: the final character returns everything to its reset value.
   always_comb begin
      pend_in  = pend_ff;
      value_in = value_ff;
      frac_in  = frac_ff;
      dot_in   = dot_ff;
      stop_in  = stop_ff;
      len_in   = len_ff;
      name_in  = name_ff;
      over_in  = over_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_last_char) begin
            pend_in  = PEND_NONE;
            value_in = '0;
            frac_in  = '0;
            dot_in   = 1'b0;
            stop_in  = 1'b0;
            len_in   = '0;
            name_in  = '0;
            over_in  = 1'b0;
            count_in = '0;
         end else begin
            pend_in  = n_pend;
            value_in = n_value;
            frac_in  = n_frac;
            dot_in   = n_dot;
            stop_in  = n_stop;
            len_in   = n_len;
            name_in  = n_name;
            over_in  = n_over;
            count_in = cnt2;
         end
      end
   end

   // Run and count state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= PEND_NONE;
         value_ff <= '0;
         frac_ff  <= '0;
         dot_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         len_ff   <= '0;
         name_ff  <= '0;
         over_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         value_ff <= value_in;
         frac_ff  <= frac_in;
         dot_ff   <= dot_in;
         stop_ff  <= stop_in;
         len_ff   <= len_in;
         name_ff  <= name_in;
         over_ff  <= over_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/etok_queue.sv =====
`timescale 1ns / 1ps
// Short queue of token groups between the front and back parts.
// Depends on etok_pkg for the entry type and the queue depth.
module etok_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  etok_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output etok_pkg::entry_type head_entry
);

   localparam int unsigned PTR_W = (etok_pkg::QUEUE_DEPTH > 1) ? $clog2(etok_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(etok_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(etok_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(etok_pkg::QUEUE_DEPTH);

   etok_pkg::entry_type mem_ff [etok_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = count_ff == CNT_FULL;
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("token group written into a full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("token group taken from an empty queue");

endmodule

// ===== src/etok_back.sv =====
`timescale 1ns / 1ps
// Back part: sends the tokens of each queued group, one per cycle while rsp_ready is high.
// Depends on etok_pkg; reads the head of etok_queue and sends results through an output register.
module etok_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  head_valid,
   input  etok_pkg::entry_type                   head_entry,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [etok_pkg::KIND_W-1:0]           rsp_token_kind,
   output logic [etok_pkg::SYM_W-1:0]            rsp_symbol,
   output logic [etok_pkg::NAME_W-1:0]           rsp_name_chars,
   output logic [etok_pkg::MANT_W-1:0]           rsp_mantissa,
   output logic [etok_pkg::FRAC_W-1:0]           rsp_frac_digits,
   output logic [etok_pkg::INDEX_W-1:0]          rsp_token_index,
   output logic                                  rsp_run_truncated,
   output logic                                  rsp_table_full,
   output logic                                  rsp_last_of_run
);

   logic [etok_pkg::NUM_SLOTS-1:0] done_ff, done_in;
   logic [etok_pkg::NUM_SLOTS-1:0] remaining, sel_mask, rest;
   logic [etok_pkg::SLOT_W-1:0]    sel;
   logic                           load;
   logic                           valid_ff, valid_in;
   etok_pkg::token_type            tok_ff;
   logic                           last_ff;

   // Pick the first token of the head group not yet sent.
   always_comb begin
      remaining = head_entry.vld & ~done_ff;
      if (remaining[etok_pkg::SLOT_RUN]) begin
         sel = etok_pkg::SLOT_RUN;
      end else if (remaining[etok_pkg::SLOT_OWN]) begin
         sel = etok_pkg::SLOT_OWN;
      end else begin
         sel = etok_pkg::SLOT_END;
      end
      sel_mask      = '0;
      sel_mask[sel] = 1'b1;
      rest          = remaining & ~sel_mask;
   end

   assign load = head_valid && (!valid_ff || rsp_ready);
   assign pop  = load && (rest == '0);

   // Sent-token mask and output valid.
   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         done_in  = (rest == '0) ? '0 : (done_ff | sel_mask);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= head_entry.tok[sel];
         last_ff <= rest == '0;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_token_kind    = tok_ff.kind;
   assign rsp_symbol        = tok_ff.symbol;
   assign rsp_name_chars    = tok_ff.name_chars;
   assign rsp_mantissa      = tok_ff.mantissa;
   assign rsp_frac_digits   = tok_ff.frac_digits;
   assign rsp_token_index   = tok_ff.token_index;
   assign rsp_run_truncated = tok_ff.run_truncated;
   assign rsp_table_full    = tok_ff.table_full;
   assign rsp_last_of_run   = last_ff;

endmodule

// ===== bench/expression_tokenizer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for expression_tokenizer_core: sends ASCII expressions and checks tokens.
// Depends on etok_pkg and the core; expected tokens come from a lexer predictor in this file.
module expression_tokenizer_core_test;

   localparam int unsigned TABLE_SIZE   = 32;
   localparam int unsigned NUMBER_CHARS = 9;
   localparam int unsigned NAME_CHARS   = 4;
   localparam int CLOCK_PERIOD  = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_CHARS  = 70;

   localparam logic [7:0] SYMBOL_CHARS [14] = '{etok_pkg::CH_PLUS, etok_pkg::CH_MINUS,
      etok_pkg::CH_STAR, etok_pkg::CH_SLASH, etok_pkg::CH_CARET, etok_pkg::CH_PERCENT,
      etok_pkg::CH_TILDE, etok_pkg::CH_COLON, etok_pkg::CH_BANG, etok_pkg::CH_PIPE,
      etok_pkg::CH_LPAREN, etok_pkg::CH_RPAREN, etok_pkg::CH_LBRACK, etok_pkg::CH_RBRACK};

   typedef enum logic [1:0] {RUN_NONE, RUN_NUMBER, RUN_NAME} run_kind_type;
   typedef enum logic [2:0] {CLS_NUMBER, CLS_LETTER, CLS_OPER, CLS_BRACKET, CLS_OTHER}
      char_class_type;

   typedef struct packed {
      logic [etok_pkg::KIND_W-1:0]  kind;
      logic [etok_pkg::SYM_W-1:0]   symbol;
      logic [etok_pkg::NAME_W-1:0]  name_chars;
      logic [etok_pkg::MANT_W-1:0]  mantissa;
      logic [etok_pkg::FRAC_W-1:0]  frac_digits;
      logic [etok_pkg::INDEX_W-1:0] token_index;
      logic                         run_truncated;
      logic                         table_full;
      logic                         last_of_run;
   } expected_type;

   logic                         clock;
   logic                         reset;
   logic [7:0]                   req_char_code;
   logic                         req_last_char;
   logic                         req_valid;
   logic                         req_ready;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [etok_pkg::KIND_W-1:0]  rsp_token_kind;
   logic [etok_pkg::SYM_W-1:0]   rsp_symbol;
   logic [etok_pkg::NAME_W-1:0]  rsp_name_chars;
   logic [etok_pkg::MANT_W-1:0]  rsp_mantissa;
   logic [etok_pkg::FRAC_W-1:0]  rsp_frac_digits;
   logic [etok_pkg::INDEX_W-1:0] rsp_token_index;
   logic                         rsp_run_truncated;
   logic                         rsp_table_full;
   logic                         rsp_last_of_run;

   // Lexer state of the predictor.
   run_kind_type                 run_kind;
   logic [etok_pkg::MANT_W-1:0]  num_value;
   logic [etok_pkg::FRAC_W-1:0]  num_frac;
   logic                         dot_seen;
   logic                         value_stopped;
   logic                         run_overlong;
   logic [etok_pkg::RUN_W-1:0]   run_len;
   logic [etok_pkg::NAME_W-1:0]  name_buf;
   logic [etok_pkg::INDEX_W-1:0] tok_count;

   int                           group_count;
   expected_type                 expected_tokens [$];
   logic [7:0]                   expr_buf [$];

   int                           mismatches = 0;
   int                           tokens_checked = 0;
   int                           full_tokens = 0;
   int                           chars_sent = 0;
   int                           expressions_sent = 0;
   int                           cycle_count = 0;
   int                           hold_request = 0;
   bit                           steady_flow = 1'b0;

   expression_tokenizer_core #(
      .MAX_TOKENS       (TABLE_SIZE),
      .MAX_NUMBER_CHARS (NUMBER_CHARS),
      .MAX_NAME_CHARS   (NAME_CHARS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_char_code     (req_char_code),
      .req_last_char     (req_last_char),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_symbol        (rsp_symbol),
      .rsp_name_chars    (rsp_name_chars),
      .rsp_mantissa      (rsp_mantissa),
      .rsp_frac_digits   (rsp_frac_digits),
      .rsp_token_index   (rsp_token_index),
      .rsp_run_truncated (rsp_run_truncated),
      .rsp_table_full    (rsp_table_full),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Ends a run that goes past the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Sorts a character into the lexer's classes.
   function automatic char_class_type classify(input logic [7:0] c);
      if ((c >= etok_pkg::CH_DIGIT0 && c <= etok_pkg::CH_DIGIT9) || c == etok_pkg::CH_DOT)
         return CLS_NUMBER;
      if ((c >= etok_pkg::CH_UPPER_A && c <= etok_pkg::CH_UPPER_Z) ||
          (c >= etok_pkg::CH_LOWER_A && c <= etok_pkg::CH_LOWER_Z))
         return CLS_LETTER;
      case (c)
         etok_pkg::CH_PLUS, etok_pkg::CH_MINUS, etok_pkg::CH_STAR, etok_pkg::CH_SLASH,
         etok_pkg::CH_CARET, etok_pkg::CH_PERCENT, etok_pkg::CH_TILDE, etok_pkg::CH_COLON,
         etok_pkg::CH_BANG, etok_pkg::CH_PIPE: return CLS_OPER;
         etok_pkg::CH_LPAREN, etok_pkg::CH_RPAREN, etok_pkg::CH_LBRACK,
         etok_pkg::CH_RBRACK: return CLS_BRACKET;
         default: return CLS_OTHER;
      endcase
   endfunction

   function automatic logic [7:0] random_symbol();
      return SYMBOL_CHARS[4'($urandom_range(0, 13))];
   endfunction

   function automatic void clear_run();
      run_kind      = RUN_NONE;
      num_value     = '0;
      num_frac      = '0;
      dot_seen      = 1'b0;
      value_stopped = 1'b0;
      run_overlong  = 1'b0;
      run_len       = '0;
      name_buf      = '0;
   endfunction

   // Queues one token caused by the current character; the count saturates.
   function automatic void emit_token(input logic [etok_pkg::KIND_W-1:0] kind,
                                      input logic [etok_pkg::SYM_W-1:0] sym,
                                      input logic [etok_pkg::NAME_W-1:0] chars,
                                      input logic [etok_pkg::MANT_W-1:0] mant,
                                      input logic [etok_pkg::FRAC_W-1:0] frac,
                                      input logic trunc);
      expected_type t;
      t.kind          = kind;
      t.symbol        = sym;
      t.name_chars    = chars;
      t.mantissa      = mant;
      t.frac_digits   = frac;
      t.token_index   = tok_count;
      t.run_truncated = trunc;
      t.table_full    = (tok_count >= TABLE_SIZE);
      t.last_of_run   = 1'b0;
      expected_tokens.push_back(t);
      group_count++;
      if (tok_count < TABLE_SIZE) tok_count++;
   endfunction

   function automatic void flush_run();
      case (run_kind)
         RUN_NUMBER: emit_token(etok_pkg::KIND_NUMBER, '0, '0, num_value, num_frac,
                                run_overlong);
         RUN_NAME:   emit_token(etok_pkg::KIND_NAME, '0, name_buf, '0, '0, run_overlong);
         default: ;
      endcase
      clear_run();
   endfunction

   // Works out the tokens caused by one accepted character and queues them.
   function automatic void predict_tokens(input logic [7:0] c, input logic last);
      expected_type t;
      group_count = 0;
      case (classify(c))
         CLS_NUMBER: begin
            if (run_kind != RUN_NUMBER) begin
               flush_run();
               run_kind = RUN_NUMBER;
            end
            if (run_len >= NUMBER_CHARS) begin
               run_overlong = 1'b1;
            end else begin
               run_len++;
               // A second dot freezes the value; later digits only lengthen the run.
               if (c == etok_pkg::CH_DOT) begin
                  if (dot_seen) value_stopped = 1'b1;
                  dot_seen = 1'b1;
               end else if (!value_stopped) begin
                  num_value = etok_pkg::MANT_W'(num_value * 10 + (c - etok_pkg::CH_DIGIT0));
                  if (dot_seen) num_frac++;
               end
            end
         end
         CLS_LETTER: begin
            if (run_kind != RUN_NAME) begin
               flush_run();
               run_kind = RUN_NAME;
            end
            if (run_len >= NAME_CHARS) begin
               run_overlong = 1'b1;
            end else begin
               name_buf[8 * run_len +: 8] = c;
               run_len++;
            end
         end
         CLS_OPER: begin
            flush_run();
            emit_token(etok_pkg::KIND_OPER, c, '0, '0, '0, 1'b0);
         end
         CLS_BRACKET: begin
            flush_run();
            emit_token(etok_pkg::KIND_BRACKET, c, '0, '0, '0, 1'b0);
         end
         default: flush_run();
      endcase
      // The final character flushes the run and closes the expression with its count.
      if (last) begin
         flush_run();
         emit_token(etok_pkg::KIND_END, '0, '0, '0, '0, 1'b0);
         tok_count = '0;
      end
      // Mark the last token of this character's group.
      if (group_count > 0) begin
         t = expected_tokens.pop_back();
         t.last_of_run = 1'b1;
         expected_tokens.push_back(t);
      end
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Checks every accepted token against the oldest expectation.
   always @(posedge clock) begin
      expected_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, kind %0d index %0d", $time, rsp_token_kind,
                     rsp_token_index);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            compare_field("token_kind", 32'(want.kind), 32'(rsp_token_kind));
            compare_field("symbol", 32'(want.symbol), 32'(rsp_symbol));
            compare_field("name_chars", want.name_chars, rsp_name_chars);
            compare_field("mantissa", 32'(want.mantissa), 32'(rsp_mantissa));
            compare_field("frac_digits", 32'(want.frac_digits), 32'(rsp_frac_digits));
            compare_field("token_index", 32'(want.token_index), 32'(rsp_token_index));
            compare_field("run_truncated", 32'(want.run_truncated), 32'(rsp_run_truncated));
            compare_field("table_full", 32'(want.table_full), 32'(rsp_table_full));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
            tokens_checked++;
            if (rsp_table_full) full_tokens++;
         end
      end
   end

   // Token receiver: random stalls, a stall-free mode, and one long hold-off on request.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && hold_request > 0) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (hold_request) @(negedge clock);
         end
         rsp_ready <= steady_flow || ($urandom_range(0, 99) >= 8);
      end
   end

   // Offers one character and returns at the falling edge after it is accepted.
   task automatic send_char(input logic [7:0] c, input logic last);
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < 8) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_char_code <= c;
      req_last_char <= last;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tokens(c, last);
      @(negedge clock);
   endtask

   task automatic send_expression();
      int i;
      for (i = 0; i < expr_buf.size(); i++) send_char(expr_buf[i], i == expr_buf.size() - 1);
      chars_sent += expr_buf.size();
      expressions_sent++;
   endtask

   task automatic append_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
   endtask

   // Stops offering items until every expected token has arrived, or the wait runs out.
   task automatic pause_until_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      @(negedge clock);
   endtask

   task automatic test_operators_and_brackets();
      expr_buf.delete();
      append_text("(+-*/^%~:!|[])");
      send_expression();
   endtask

   // Over-long name, unknown characters at both ends of the code range, an over-long number
   // with a second dot, a lone dot as the final character, and an expression of only the end token.
   task automatic test_runs_and_special_cases();
      expr_buf.delete();
      append_text("AZazb");
      expr_buf.push_back(8'h00);
      append_text("12.3.456789");
      expr_buf.push_back(8'hFF);
      append_text(".");
      send_expression();
      expr_buf.delete();
      append_text(" ");
      send_expression();
   endtask

   // More tokens than the table holds, so the index saturates and the full flag rises.
   task automatic test_table_overflow();
      expr_buf.delete();
      repeat (TABLE_SIZE + 6) expr_buf.push_back(random_symbol());
      send_expression();
   endtask

   // The receiver holds off while characters keep coming, so the core fills and stalls.
   task automatic test_back_pressure();
      hold_request = HOLD_CYCLES;
      steady_flow  = 1'b1;
      expr_buf.delete();
      append_text("(ab+12.5)*[x-3]/foo^2%7|q");
      send_expression();
      steady_flow = 1'b0;
      pause_until_drained();
   endtask

   // Mostly well-formed expressions of numbers, names and symbols, with some noise.
   task automatic build_random_expression();
      int n_tokens;
      int len;
      int pick;
      expr_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, 8);
         repeat (len) expr_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         n_tokens = $urandom_range(1, 8);
         repeat (n_tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               if ($urandom_range(0, 9) == 0) begin
                  // Largest mantissa, sometimes with one digit too many.
                  repeat ($urandom_range(9, 10)) expr_buf.push_back(etok_pkg::CH_DIGIT9);
               end else begin
                  len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
                  repeat (len) begin
                     if ($urandom_range(0, 6) == 0) expr_buf.push_back(etok_pkg::CH_DOT);
                     else expr_buf.push_back(8'(etok_pkg::CH_DIGIT0 + $urandom_range(0, 9)));
                  end
               end
            end else if (pick < 60) begin
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 1) == 1)
                     expr_buf.push_back(8'(etok_pkg::CH_UPPER_A + $urandom_range(0, 25)));
                  else
                     expr_buf.push_back(8'(etok_pkg::CH_LOWER_A + $urandom_range(0, 25)));
               end
            end else if (pick < 88) begin
               expr_buf.push_back(random_symbol());
            end else begin
               expr_buf.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic test_random_expressions();
      int sent;
      int count;
      sent  = 0;
      count = 0;
      while (sent < RANDOM_CHARS) begin
         // A stretch of expressions with no idling on either side.
         steady_flow = (count >= 2 && count < 5);
         build_random_expression();
         send_expression();
         sent += expr_buf.size();
         count++;
      end
      steady_flow = 1'b0;
   endtask

   task automatic finish_run();
      int missing;
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      missing = expected_tokens.size();
      if (missing != 0) begin
         $display("%0t: outstanding tokens expected 0, actual %0d", $time, missing);
      end
      $display("Sent %0d characters in %0d expressions and checked %0d tokens.", chars_sent,
               expressions_sent, tokens_checked);
      $display("%0d tokens came with the table full; one receiver hold-off of %0d cycles.",
               full_tokens, HOLD_CYCLES);
      if (mismatches == 0 && missing == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_last_char = 1'b0;
      clear_run();
      tok_count = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_operators_and_brackets();
      test_runs_and_special_cases();
      test_table_overflow();
      test_back_pressure();
      test_random_expressions();
      finish_run();
   end

endmodule
